// File: hdl/drrd_pkg.sv
// Shared types, constants and helpers for the dark row run detector.
// No dependencies; imported by every module of the block.
package drrd_pkg;

    localparam int MAX_LINES  = 5;
    localparam int MAX_DIM    = 256;
    localparam int POS_W      = 8;
    localparam int CNT_W      = 9;
    localparam int CFG_W      = 9;
    localparam int LINE_W     = 3;
    localparam int PIX_W      = 16;
    localparam int OUT_DATA_W = 24;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DARK_THRESH  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
        logic [CFG_W-1:0] dark_count_threshold;
    } drrd_cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_index;
        logic [POS_W-1:0]  line_end_row;
        logic [POS_W-1:0]  line_start_row;
    } drrd_line_t;

    // Last valid position for a size register: zero acts as one, above MAX_DIM clamps.
    function automatic logic [POS_W-1:0] last_pos(input logic [CFG_W-1:0] size);
        logic [POS_W-1:0] r;
        if (size == '0)
        begin
            r = '0;
        end
        else if (size > CFG_W'(MAX_DIM))
        begin
            r = POS_W'(MAX_DIM - 1);
        end
        else
        begin
            r = POS_W'(size - CFG_W'(1));
        end
        return r;
    endfunction

endpackage

// File: hdl/drrd_cfg.sv
// APB register file: image width, image height, dark count threshold.
// Depends on drrd_pkg.
module drrd_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [drrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [drrd_pkg::PDATA_W-1:0]  pwdata,
    output logic [drrd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output drrd_pkg::drrd_cfg_t           cfg
);
    import drrd_pkg::*;

    drrd_cfg_t  cfg_reg;
    drrd_cfg_t  cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  cfg_next.image_width          = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height         = pwdata[CFG_W-1:0];
                REG_DARK_THRESH:  cfg_next.dark_count_threshold = pwdata[CFG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg_reg.image_height);
            REG_DARK_THRESH:  prdata = PDATA_W'(cfg_reg.dark_count_threshold);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width          <= CFG_W'(240);
            cfg_reg.image_height         <= CFG_W'(240);
            cfg_reg.dark_count_threshold <= CFG_W'(120);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/drrd_core.sv
// Pixel input register, row/column counters, black count and run tracking.
// Depends on drrd_pkg.
module drrd_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  drrd_pkg::drrd_cfg_t         cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [drrd_pkg::PIX_W-1:0]  s_tdata,
    input  logic                        room,
    output logic                        push,
    output drrd_pkg::drrd_line_t        push_line
);
    import drrd_pkg::*;

    logic              pix_valid_reg;
    logic              pix_valid_next;
    logic [PIX_W-1:0]  pix_reg;
    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  col_next;
    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  row_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              run_open_reg;
    logic              run_open_next;
    logic [POS_W-1:0]  first_row_reg;
    logic [POS_W-1:0]  first_row_next;
    logic [LINE_W-1:0] lines_reg;
    logic [LINE_W-1:0] lines_next;

    logic              proceed;
    logic              s_accept;
    logic [CNT_W-1:0]  cnt_inc;
    logic [POS_W-1:0]  w_last;
    logic [POS_W-1:0]  h_last;
    logic              row_end;
    logic              last_row;
    logic              dark;
    logic              report;

    assign proceed  = pix_valid_reg && room;
    assign s_tready = !pix_valid_reg || proceed;
    assign s_accept = s_tvalid && s_tready;

    assign w_last   = last_pos(cfg.image_width);
    assign h_last   = last_pos(cfg.image_height);
    assign cnt_inc  = cnt_reg + CNT_W'((pix_reg == '0) && (cnt_reg != '1));
    assign row_end  = col_reg >= w_last;
    assign last_row = row_reg >= h_last;
    assign dark     = cnt_inc >= cfg.dark_count_threshold;
    assign report   = proceed && row_end && !dark && run_open_reg && !last_row
                      && (lines_reg < LINE_W'(MAX_LINES));

    assign push                     = report;
    assign push_line.line_start_row = first_row_reg;
    assign push_line.line_end_row   = row_reg - POS_W'(1);
    assign push_line.line_index     = lines_reg;

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        run_open_next  = run_open_reg;
        first_row_next = first_row_reg;
        lines_next     = lines_reg;

        if (s_accept)
        begin
            pix_valid_next = 1'b1;
        end
        else if (proceed)
        begin
            pix_valid_next = 1'b0;
        end

        if (proceed)
        begin
            if (!row_end)
            begin
                col_next = col_reg + POS_W'(1);
                cnt_next = cnt_inc;
            end
            else
            begin
                col_next = '0;
                cnt_next = '0;
                if (dark)
                begin
                    if (!run_open_reg)
                    begin
                        run_open_next  = 1'b1;
                        first_row_next = row_reg;
                    end
                end
                else
                begin
                    run_open_next = 1'b0;
                end
                if (report)
                begin
                    lines_next = lines_reg + LINE_W'(1);
                end
                if (last_row)
                begin
                    row_next       = '0;
                    run_open_next  = 1'b0;
                    first_row_next = '0;
                    lines_next     = '0;
                end
                else
                begin
                    row_next = row_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            pix_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            run_open_reg  <= 1'b0;
            first_row_reg <= '0;
            lines_reg     <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            run_open_reg  <= run_open_next;
            first_row_reg <= first_row_next;
            lines_reg     <= lines_next;
        end
    end

endmodule

// File: hdl/drrd_out.sv
// Two-word result buffer driving the master stream side.
// Depends on drrd_pkg.
module drrd_out (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  drrd_pkg::drrd_line_t             push_line,
    output logic                             room,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [drrd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import drrd_pkg::*;

    drrd_line_t ent_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;
    drrd_line_t head;

    assign room     = count_reg != 2'd2;
    assign m_tvalid = count_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign head     = ent_reg[rd_ptr_reg];
    assign m_tdata  = OUT_DATA_W'(head);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/dark_row_run_detector.sv
// Top level of the dark row run detector: register file, pixel core, result buffer.
// Depends on drrd_pkg, drrd_cfg, drrd_core, drrd_out.
//
// Takes one pixel per clock in raster order and reports each dark-row run
// (first row, last row, index in frame) that a non-dark row other than the
// frame's last closes, up to MAX_LINES per frame, on that row's last pixel.
// A pixel passes through an input register. Once the result buffer has room,
// the counters and compare update and any report is written into the result
// buffer, which drives m_tvalid. The result side is a two-word buffer; the pixel
// side stalls only when that buffer is full. Size and threshold registers take
// effect immediately and are meant to be written while no word is in flight.
module dark_row_run_detector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [drrd_pkg::PADDR_W-1:0]     paddr,
    input  logic [drrd_pkg::PDATA_W-1:0]     pwdata,
    output logic [drrd_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [drrd_pkg::PIX_W-1:0]       s_tdata,   // [15:0] pixel_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [drrd_pkg::OUT_DATA_W-1:0]  m_tdata    // [7:0] line_start_row,
                                                        // [15:8] line_end_row,
                                                        // [18:16] line_index, zero above
);
    import drrd_pkg::*;

    drrd_cfg_t  cfg;
    logic       room;
    logic       push;
    drrd_line_t push_line;

    drrd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drrd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .room      (room),
        .push      (push),
        .push_line (push_line)
    );

    drrd_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_line (push_line),
        .room      (room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hdl/drrd_checker.sv
// Port-level checks for dark_row_run_detector, attached by bind.
// Depends on drrd_pkg.
module drrd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic [drrd_pkg::PDATA_W-1:0]     prdata,
    input logic                             pready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [drrd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import drrd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:19] == 5'd0 && m_tdata[18:16] < 3'(MAX_LINES))
        else $error("line index or padding out of range");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:8] >= m_tdata[7:0])
        else $error("run ends before it starts");

    a_regs: assert property (@(posedge clk) disable iff (!rst_n)
        pready && prdata[31:9] == 23'd0)
        else $error("register read wider than 9 bits or not ready");

endmodule

bind dark_row_run_detector drrd_checker u_drrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .prdata   (prdata),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
